// ===== src/rrca_pkg.sv =====
// Shared types and constants for the round-robin channel averager.
package rrca_pkg;

	// Block geometry
	localparam int SAMPLES_PER_CHANNEL = 38;
	localparam int NUM_CHANNELS        = 6;

	// Field widths
	localparam int SAMPLE_W = 10;
	localparam int CH_W     = 3;
	localparam int CNT_W    = 6;
	localparam int SUM_W    = 16;

	// Divide by the block size as a multiply by a rounded-up reciprocal.
	// With DIV_SHIFT = SUM_W + CNT_W the result is exact for every sum.
	localparam int DIV_SHIFT = SUM_W + CNT_W;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam longint unsigned DIV_RECIP =
		((64'd1 << DIV_SHIFT) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;
	localparam int PROD_W = SUM_W + RECIP_W;

	// Stream data widths
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	// Completed block handed from the accumulator to the divider
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CH_W-1:0]  finished_channel;
		logic [CH_W-1:0]  next_channel;
	} rrca_block_t;

endpackage

// ===== src/round_robin_channel_averager_core.sv =====
// Top level of the round-robin channel averager.
//
// Takes one 10-bit sample per transaction from the channel currently selected
// and sums 38 samples per channel. The sample that completes a block produces
// one result transaction carrying the channel, the truncated mean and the
// select for the following samples; the select steps round-robin over six
// channels. One sample is taken every clock cycle while the output side keeps
// up; a block's result reaches the output through the input register, the sum
// register and the output register. Samples that do not complete a block give
// no output transaction.
module round_robin_channel_averager_core
	import rrca_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // [2:0] finished_channel,
	                                              // [12:3] average,
	                                              // [15:13] next_channel
);

	logic        blk_valid;
	logic        blk_ready;
	rrca_block_t blk;

	// Accumulate samples and track the channel select
	rrca_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata[SAMPLE_W-1:0]),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk       (blk)
	);

	// Divide the block sum and present the result
	rrca_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk       (blk),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== src/rrca_accum.sv =====
// Input and block registers, accumulator, sample counter and channel select.
module rrca_accum
	import rrca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                blk_valid,
	input  logic                blk_ready,
	output rrca_block_t         blk
);

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CH_W-1:0]     channel_q;
	logic [CNT_W-1:0]    left_q;
	logic [SUM_W-1:0]    sum_q;
	logic                valid_s2;
	rrca_block_t         blk_s2;

	logic                s2_ready;
	logic                adv_s1;
	logic                done;
	logic [SUM_W-1:0]    sum_next;
	logic [CH_W:0]       chan_inc;
	logic [CH_W-1:0]     chan_next;

	// Handshake between stages
	assign s2_ready = !valid_s2 || blk_ready;
	assign adv_s1   = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;

	// Accumulate and pick the next channel
	assign sum_next  = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, sample_s1};
	assign done      = (left_q <= CNT_W'(1));
	assign chan_inc  = {1'b0, channel_q} + (CH_W+1)'(1);
	assign chan_next = (chan_inc >= (CH_W+1)'(NUM_CHANNELS)) ? '0 : chan_inc[CH_W-1:0];

	// Capture the incoming sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_sample;
		end
	end

	// Advance the block state once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
			left_q    <= CNT_W'(SAMPLES_PER_CHANNEL);
			sum_q     <= '0;
		end else if (adv_s1) begin
			if (done) begin
				channel_q <= chan_next;
				left_q    <= CNT_W'(SAMPLES_PER_CHANNEL);
				sum_q     <= '0;
			end else begin
				left_q <= left_q - CNT_W'(1);
				sum_q  <= sum_next;
			end
		end
	end

	// Hold a completed block until the divider takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= adv_s1 && done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && done && s2_ready) begin
			blk_s2.sum              <= sum_next;
			blk_s2.finished_channel <= channel_q;
			blk_s2.next_channel     <= chan_next;
		end
	end

	assign blk_valid = valid_s2;
	assign blk       = blk_s2;

endmodule

// ===== src/rrca_divide.sv =====
// Reciprocal-multiply divider and output register for completed blocks.
module rrca_divide
	import rrca_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  blk_valid,
	output logic                  blk_ready,
	input  rrca_block_t           blk,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] mean;
	logic                tvalid_q;
	logic [CH_W-1:0]     finished_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [CH_W-1:0]     next_q;

	// Truncated mean: sum times reciprocal, then drop the fraction bits
	assign prod = {{RECIP_W{1'b0}}, blk.sum} * PROD_W'(DIV_RECIP);
	assign mean = prod[DIV_SHIFT +: SAMPLE_W];

	assign blk_ready = !tvalid_q || out_ready;

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (blk_ready) begin
			tvalid_q <= blk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_valid && blk_ready) begin
			finished_q <= blk.finished_channel;
			mean_q     <= mean;
			next_q     <= blk.next_channel;
		end
	end

	assign out_valid = tvalid_q;
	assign out_data  = {next_q, mean_q, finished_q};

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the round-robin channel averager core.
`timescale 1ns / 100ps

module testbench;
	import rrca_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// Block patterns used by the sample generator
	typedef enum int {
		PAT_UNIFORM,
		PAT_ALL_MAX,
		PAT_ALL_ZERO,
		PAT_NEAR_MAX,
		PAT_EXTREMES,
		PAT_LOW
	} block_pattern_t;

	// One channel average as it appears on the output stream
	typedef struct packed {
		logic [CH_W-1:0]     next_channel;
		logic [SAMPLE_W-1:0] average;
		logic [CH_W-1:0]     finished_channel;
	} channel_average_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [9:0] sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [2:0] finished_channel,
	                                            // [12:3] average,
	                                            // [15:13] next_channel

	// Stimulus and expectation stores
	logic [SAMPLE_W-1:0] pending_samples[$];
	channel_average_t    expected_averages[$];

	// Predictor state
	logic [CH_W-1:0]  model_channel = '0;
	logic [CNT_W-1:0] model_samples_left = CNT_W'(SAMPLES_PER_CHANNEL);
	logic [SUM_W-1:0] model_sum = '0;

	// Run bookkeeping
	logic sample_taken = 1'b0;
	int   accepted_samples = 0;
	int   checked_averages = 0;
	int   error_count = 0;
	int   input_stall_cycles = 0;
	int   cycle_count = 0;
	int   averages_per_channel[NUM_CHANNELS];

	// Idle control
	int tx_gap_left = 0;
	int tx_calm_left = 0;
	int rx_stall_left = 0;
	int rx_calm_left = 0;
	int hold_cycles = 0;
	int holds_done = 0;
	int hold_start[2] = '{300, 700};
	logic [SAMPLE_W-1:0] next_sample;

	round_robin_channel_averager_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// Mostly no pause, sometimes a short one, rarely a long one
	function automatic int draw_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 60);
	endfunction

	// Accumulate one sample; queue the channel average when the block completes
	task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value);
		channel_average_t result;
		logic [CH_W-1:0]  done_channel;
		done_channel = model_channel;
		model_sum = model_sum + SUM_W'(value);
		if (model_samples_left > 1) begin
			model_samples_left = model_samples_left - 1'b1;
		end else begin
			result.finished_channel = done_channel;
			result.average = SAMPLE_W'(model_sum / SAMPLES_PER_CHANNEL);
			if (int'(done_channel) + 1 >= NUM_CHANNELS)
				result.next_channel = '0;
			else
				result.next_channel = done_channel + 1'b1;
			expected_averages.push_back(result);
			model_channel = result.next_channel;
			model_samples_left = CNT_W'(SAMPLES_PER_CHANNEL);
			model_sum = '0;
		end
	endtask

	// Drive samples from the pending queue, idling between transactions
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || sample_taken)) begin
			if (tx_gap_left > 0 && hold_cycles == 0) begin
				tx_gap_left = tx_gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				next_sample = pending_samples.pop_front();
				s_axis_tdata <= {{(IN_DATA_W - SAMPLE_W){1'b0}}, next_sample};
				s_axis_tvalid <= 1'b1;
				if (tx_calm_left > 0) begin
					tx_calm_left = tx_calm_left - 1;
					tx_gap_left = 0;
				end else begin
					tx_gap_left = draw_pause();
					if ($urandom_range(0, 49) == 0)
						tx_calm_left = $urandom_range(40, 120);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Hold the output side off for a long stretch, twice per run
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
			end else if (holds_done < 2 && accepted_samples >= hold_start[holds_done]) begin
				hold_cycles <= HOLD_OFF_CYCLES;
				holds_done <= holds_done + 1;
			end
		end
	end

	// Stall the output side at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left = rx_stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_calm_left > 0) begin
					rx_calm_left = rx_calm_left - 1;
				end else begin
					rx_stall_left = draw_pause();
					if ($urandom_range(0, 49) == 0)
						rx_calm_left = $urandom_range(40, 120);
				end
			end
		end
	end

	// Predict on accepted samples and check each result transaction
	always @(posedge clk) begin
		channel_average_t got;
		channel_average_t want;
		sample_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && !s_axis_tready)
				input_stall_cycles = input_stall_cycles + 1;
			if (s_axis_tvalid && s_axis_tready) begin
				accumulate_sample(s_axis_tdata[SAMPLE_W-1:0]);
				accepted_samples = accepted_samples + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = channel_average_t'(m_axis_tdata);
				if (expected_averages.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("%0t: unexpected result: channel %0d average %0d next %0d",
							$realtime, got.finished_channel, got.average, got.next_channel);
					error_count = error_count + 1;
				end else begin
					want = expected_averages.pop_front();
					checked_averages = checked_averages + 1;
					if (int'(want.finished_channel) < NUM_CHANNELS)
						averages_per_channel[want.finished_channel] =
							averages_per_channel[want.finished_channel] + 1;
					if (got.finished_channel !== want.finished_channel ||
					    got.average !== want.average ||
					    got.next_channel !== want.next_channel) begin
						if (error_count < MAX_REPORTS)
							$display({"%0t: result %0d mismatch: channel %0d/%0d ",
								"average %0d/%0d next %0d/%0d (expected/actual)"},
								$realtime, checked_averages,
								want.finished_channel, got.finished_channel,
								want.average, got.average,
								want.next_channel, got.next_channel);
						error_count = error_count + 1;
					end
				end
			end
		end
	end

	// Bound the run time
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding",
				$realtime, expected_averages.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Build stimulus, reset, then wait for the stream to drain
	initial begin
		block_pattern_t pattern;
		int             total;
		int             blocks;
		logic [SAMPLE_W-1:0] value;

		// Directed: field extremes and alternating bit patterns
		pending_samples = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd512,
			10'd1022, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'h200, 10'h1FF,
			10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd37, 10'd38,
			10'd1023, 10'd0, 10'h3F0, 10'h00F, 10'd1023};
		total = pending_samples.size();
		pattern = PAT_UNIFORM;

		// Random: fill block 0 uniformly, then whole blocks, a pattern each
		while (total < 900 || total % SAMPLES_PER_CHANNEL != 0) begin
			if (total % SAMPLES_PER_CHANNEL == 0) begin
				blocks = total / SAMPLES_PER_CHANNEL;
				if (blocks == 1)
					pattern = PAT_ALL_MAX;
				else if (blocks == 2)
					pattern = PAT_ALL_ZERO;
				else
					case ($urandom_range(0, 9))
						0:       pattern = PAT_ALL_MAX;
						1:       pattern = PAT_ALL_ZERO;
						2:       pattern = PAT_NEAR_MAX;
						3:       pattern = PAT_EXTREMES;
						4:       pattern = PAT_LOW;
						default: pattern = PAT_UNIFORM;
					endcase
			end
			case (pattern)
				PAT_ALL_MAX:  value = 10'd1023;
				PAT_ALL_ZERO: value = 10'd0;
				PAT_NEAR_MAX: value = SAMPLE_W'($urandom_range(990, 1023));
				PAT_EXTREMES: value = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
				PAT_LOW:      value = SAMPLE_W'($urandom_range(0, 40));
				default:      value = SAMPLE_W'($urandom_range(0, 1023));
			endcase
			pending_samples.push_back(value);
			total = total + 1;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display({"Run: %0d samples accepted, %0d channel averages checked ",
			"(per channel 0..5: %0d %0d %0d %0d %0d %0d)"},
			accepted_samples, checked_averages,
			averages_per_channel[0], averages_per_channel[1], averages_per_channel[2],
			averages_per_channel[3], averages_per_channel[4], averages_per_channel[5]);
		$display({"Run: %0d cycles with the input stalled by output back-pressure, ",
			"%0d mismatches"},
			input_stall_cycles, error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
